[sv/ecb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ecb_pkg;

    localparam logic [7:0]  CMD_WRITE = 8'h57;
    localparam logic [7:0]  CMD_READ  = 8'h52;
    localparam logic [31:0] TRAILER   = 32'hDEADBEEF;
    localparam logic [7:0]  MASK_ALL  = 8'hFF;

    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_AW      = 1;
    localparam int unsigned NUM_SLOTS = 7;

    // Each job expands into a subset of these output words, in this order.
    typedef enum logic [2:0] {
        SLOT_REF,
        SLOT_RH0,
        SLOT_RH1,
        SLOT_DATA,
        SLOT_WH0,
        SLOT_WH1,
        SLOT_TRAIL
    } t_slot;

    typedef struct packed {
        logic        operation;
        logic [63:0] data;
        logic [7:0]  keep;
        logic        last;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        port;
        logic [63:0] word;
        logic [7:0]  byte_mask;
        logic        frame_end;
        logic        run_end;
    } t_out;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slots;
        logic                 data_port;
        logic [63:0]          data_word;
        logic [7:0]           data_mask;
        logic                 data_fend;
        logic [47:0]          src_mac;
        logic [47:0]          dest_mac;
        logic [15:0]          frame_type;
        logic [7:0]           link_id;
        logic [15:0]          trail;
    } t_job;

endpackage

`default_nettype wire

[sv/ecb_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecb_front import ecb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_in  i_item,
    input  wire  i_full,
    output logic o_job_push,
    output t_job o_job
);

    logic [1:0]  r_hc, n_hc;
    logic        r_rx_busy, n_rx_busy;
    logic        r_in_frame, n_in_frame;
    logic        r_armed, n_armed;
    logic [47:0] r_dmac, n_dmac;
    logic [47:0] r_smac, n_smac;
    logic [15:0] r_type, n_type;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_cmd, n_cmd;
    logic [15:0] r_len, n_len;
    logic [15:0] r_wrem, n_wrem;
    logic [15:0] r_rxb, n_rxb;

    logic accept;
    logic ok;
    logic [15:0] rxb_base;

    function automatic logic [3:0] keep_bytes(input logic [7:0] keep);
        logic [3:0] n;
        begin
            n = 4'd0;
            case (keep)
                8'h01: n = 4'd1;
                8'h03: n = 4'd2;
                8'h07: n = 4'd3;
                8'h0F: n = 4'd4;
                8'h1F: n = 4'd5;
                8'h3F: n = 4'd6;
                8'h7F: n = 4'd7;
                8'hFF: n = 4'd8;
                default: n = 4'd0;
            endcase
            return n;
        end
    endfunction

    always_comb begin
        n_hc       = r_hc;
        n_rx_busy  = r_rx_busy;
        n_in_frame = r_in_frame;
        n_armed    = r_armed;
        n_dmac     = r_dmac;
        n_smac     = r_smac;
        n_type     = r_type;
        n_id       = r_id;
        n_cmd      = r_cmd;
        n_len      = r_len;
        n_wrem     = r_wrem;
        n_rxb      = r_rxb;
        rxb_base   = r_rxb;
        o_job      = '0;

        accept = i_push && !i_full;
        if (i_item.operation) begin
            ok = !r_in_frame && (r_rx_busy || r_armed);
        end else begin
            ok = !r_rx_busy;
        end

        if (accept) begin
            if (!ok) begin
                o_job.slots[SLOT_REF] = 1'b1;
            end else if (!i_item.operation) begin
                unique case (r_hc)
                    2'd0: begin
                        n_dmac        = i_item.data[47:0];
                        n_smac[15:0]  = i_item.data[63:48];
                        n_hc          = 2'd1;
                    end
                    2'd1: begin
                        n_smac[47:16] = i_item.data[31:0];
                        n_type        = i_item.data[47:32];
                        n_id          = i_item.data[55:48];
                        n_cmd         = i_item.data[63:56];
                        n_hc          = 2'd2;
                    end
                    2'd2: begin
                        n_len  = i_item.data[15:0];
                        n_wrem = i_item.data[15:0];
                        if (r_cmd == CMD_READ) begin
                            n_armed = 1'b1;
                        end
                        n_hc = 2'd3;
                    end
                    default: begin
                        if (r_cmd == CMD_WRITE && r_wrem != 16'd0) begin
                            o_job.slots[SLOT_DATA] = 1'b1;
                            o_job.data_port = 1'b1;
                            o_job.data_word = i_item.data;
                            if (r_wrem > 16'd8) begin
                                o_job.data_mask = i_item.keep;
                                o_job.data_fend = i_item.last;
                                n_wrem = r_wrem - 16'd8;
                            end else begin
                                o_job.data_mask = 8'((9'd1 << r_wrem[3:0]) - 9'd1);
                                o_job.data_fend = 1'b1;
                                n_wrem = 16'd0;
                            end
                        end
                    end
                endcase
                if (i_item.last) begin
                    n_hc       = 2'd0;
                    n_in_frame = 1'b0;
                    if (n_cmd == CMD_WRITE) begin
                        o_job.slots[SLOT_WH0]   = 1'b1;
                        o_job.slots[SLOT_WH1]   = 1'b1;
                        o_job.slots[SLOT_TRAIL] = 1'b1;
                    end
                end else begin
                    n_in_frame = 1'b1;
                end
            end else begin
                if (!r_rx_busy) begin
                    n_armed   = 1'b0;
                    rxb_base  = 16'd0;
                    n_rx_busy = 1'b1;
                    o_job.slots[SLOT_RH0] = 1'b1;
                    o_job.slots[SLOT_RH1] = 1'b1;
                end
                o_job.slots[SLOT_DATA] = 1'b1;
                o_job.data_port = 1'b0;
                o_job.data_word = i_item.data;
                o_job.data_mask = MASK_ALL;
                o_job.data_fend = 1'b0;
                if (i_item.last) begin
                    n_rxb     = rxb_base + {12'd0, keep_bytes(i_item.keep)};
                    n_rx_busy = 1'b0;
                    o_job.slots[SLOT_TRAIL] = 1'b1;
                end else begin
                    n_rxb = rxb_base + 16'd8;
                end
            end
        end

        o_job.src_mac    = n_smac;
        o_job.dest_mac   = n_dmac;
        o_job.frame_type = n_type;
        o_job.link_id    = n_id;
        o_job.trail      = o_job.slots[SLOT_WH0] ? n_len : n_rxb;
        o_job_push       = accept && (o_job.slots != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc       <= 2'd0;
            r_rx_busy  <= 1'b0;
            r_in_frame <= 1'b0;
            r_armed    <= 1'b0;
            r_dmac     <= '0;
            r_smac     <= '0;
            r_type     <= '0;
            r_id       <= '0;
            r_cmd      <= '0;
            r_len      <= '0;
            r_wrem     <= '0;
            r_rxb      <= '0;
        end else begin
            r_hc       <= n_hc;
            r_rx_busy  <= n_rx_busy;
            r_in_frame <= n_in_frame;
            r_armed    <= n_armed;
            r_dmac     <= n_dmac;
            r_smac     <= n_smac;
            r_type     <= n_type;
            r_id       <= n_id;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_wrem     <= n_wrem;
            r_rxb      <= n_rxb;
        end
    end

endmodule

`default_nettype wire

[sv/ecb_jobq.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecb_jobq import ecb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_wr,
    input  t_job i_job,
    output logic o_full,
    input  wire  i_rd,
    output logic o_valid,
    output t_job o_head
);

    t_job              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/ecb_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module ecb_back import ecb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  t_job i_head,
    output logic o_rd,
    output logic o_empty,
    input  wire  i_pop,
    output t_out o_result
);

    logic [NUM_SLOTS-1:0] r_done, n_done;
    logic                 r_ov;
    t_out                 r_out;

    logic [NUM_SLOTS-1:0] pend;
    logic [NUM_SLOTS-1:0] low;
    t_slot                idx;
    logic                 single;
    logic                 emit;
    t_out                 res;

    always_comb begin
        pend   = i_head.slots & ~r_done;
        low    = pend & (~pend + 1'b1);
        single = ((pend & (pend - 1'b1)) == '0);
        idx    = SLOT_REF;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (pend[k]) begin
                idx = t_slot'(k);
            end
        end

        res = '0;
        res.accepted  = 1'b1;
        res.byte_mask = MASK_ALL;
        res.run_end   = single;
        unique case (idx)
            SLOT_REF: begin
                res.accepted  = 1'b0;
                res.byte_mask = 8'h00;
            end
            SLOT_RH0, SLOT_WH0: begin
                res.word = {i_head.dest_mac[15:0], i_head.src_mac};
            end
            SLOT_RH1: begin
                res.word = {CMD_READ, i_head.link_id, i_head.link_id,
                            i_head.frame_type[7:0], i_head.dest_mac[47:16]};
            end
            SLOT_DATA: begin
                res.port      = i_head.data_port;
                res.word      = i_head.data_word;
                res.byte_mask = i_head.data_mask;
                res.frame_end = i_head.data_fend;
            end
            SLOT_WH1: begin
                res.word = {CMD_WRITE, i_head.link_id, i_head.frame_type,
                            i_head.dest_mac[47:16]};
            end
            SLOT_TRAIL: begin
                res.word      = {TRAILER, 16'd0, i_head.trail};
                res.frame_end = 1'b1;
            end
            default: begin
                res.word = '0;
            end
        endcase

        emit   = i_valid && (!r_ov || i_pop);
        o_rd   = emit && single;
        n_done = r_done;
        if (emit) begin
            n_done = single ? '0 : (r_done | low);
        end
    end

    assign o_empty  = !r_ov;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_done <= n_done;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_pend_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (pend != '0))
        else $error("queued job has no words left");

    a_refuse_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_result.accepted) |-> o_result.run_end)
        else $error("refusal word not marked as end of run");

    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_done == '0))
        else $error("progress mask set with no job waiting");
`endif

endmodule

`default_nettype wire

[sv/ethernet_command_bridge.sv]
`timescale 1ns / 1ps
`default_nettype none

// The first result word of an accepted item passes the job queue and then the output
// register before it shows on o_result. Throughput: one word per cycle while i_pop takes
// each word, and a two-entry job queue lets parsing run ahead while the output drains.
// Reset: synchronous, active low; clears the parser state and the job queue and leaves the
// output register empty.
module ethernet_command_bridge import ecb_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    output logic o_full,
    input  t_in  i_item,
    output logic o_empty,
    input  wire  i_pop,
    output t_out o_result
);

    logic q_full;
    logic q_push;
    t_job q_job;
    logic q_valid;
    logic q_rd;
    t_job q_head;

    assign o_full = q_full;

    ecb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .i_full     (q_full),
        .o_job_push (q_push),
        .o_job      (q_job)
    );

    ecb_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    ecb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_head   (q_head),
        .o_rd     (q_rd),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import ecb_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int RANDOM_WORDS  = 387;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AFTER    = 150;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_SPARSE,
        POP_TOGGLE
    } t_pop_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push  = 1'b0;
    logic i_pop   = 1'b0;
    t_in  i_item  = '0;
    logic o_full;
    logic o_empty;
    t_out o_result;

    t_in  in_words[$];
    t_out out_words_due[$];

    logic [1:0]  hdr_cnt;
    logic        fwd_active;
    logic        link_open;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ftype;
    logic [7:0]  req_id;
    logic [7:0]  cmd;
    logic [15:0] req_len;
    logic [15:0] wr_left;
    logic [15:0] pkt_bytes;
    logic        read_armed;

    int words_pushed  = 0;
    int words_popped  = 0;
    int mismatches    = 0;
    int refusals      = 0;
    int tx_words      = 0;
    int link_out      = 0;
    int stall_cycles  = 0;
    int n_directed    = 0;

    int        seen_pushed = 0;
    int        burst_left  = 0;
    int        gap_left    = 0;
    int        hold_left   = 0;
    logic      held_once   = 1'b0;
    int        mode_left   = 0;
    t_pop_mode pop_mode    = POP_ALWAYS;
    logic      progress;
    t_out      due;

    ethernet_command_bridge uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [15:0] keep_bytes(input logic [7:0] k);
        int n;
        keep_bytes = '0;
        for (n = 1; n <= 8; n++) begin
            if (k == 8'((16'd1 << n) - 16'd1)) begin
                keep_bytes = 16'(n);
            end
        end
    endfunction

    task automatic emit(input logic port, input logic [63:0] w, input logic [7:0] m,
                        input logic fend);
        t_out r;
        r.accepted  = 1'b1;
        r.port      = port;
        r.word      = w;
        r.byte_mask = m;
        r.frame_end = fend;
        r.run_end   = 1'b0;
        out_words_due.push_back(r);
        if (port) begin
            tx_words++;
        end else begin
            link_out++;
        end
    endtask

    task automatic bridge_outputs(input t_in it);
        t_out        r;
        logic [15:0] m;
        int          n_before;
        n_before = out_words_due.size();
        if (it.operation ? (link_open || !(fwd_active || read_armed)) : fwd_active) begin
            r = '0;
            r.run_end = 1'b1;
            out_words_due.push_back(r);
            refusals++;
        end else if (!it.operation) begin
            case (hdr_cnt)
                2'd0: begin
                    dst_mac = it.data[47:0];
                    src_mac[15:0] = it.data[63:48];
                    hdr_cnt = 2'd1;
                end
                2'd1: begin
                    src_mac[47:16] = it.data[31:0];
                    ftype = it.data[47:32];
                    req_id = it.data[55:48];
                    cmd = it.data[63:56];
                    hdr_cnt = 2'd2;
                end
                2'd2: begin
                    req_len = it.data[15:0];
                    wr_left = req_len;
                    if (cmd == CMD_READ) begin
                        read_armed = 1'b1;
                    end
                    hdr_cnt = 2'd3;
                end
                default: begin
                    if (cmd == CMD_WRITE && wr_left != 16'd0) begin
                        if (wr_left > 16'd8) begin
                            emit(1'b1, it.data, it.keep, it.last);
                            wr_left = wr_left - 16'd8;
                        end else begin
                            m = (16'd1 << wr_left) - 16'd1;
                            emit(1'b1, it.data, m[7:0], 1'b1);
                            wr_left = 16'd0;
                        end
                    end
                end
            endcase
            if (it.last) begin
                hdr_cnt = 2'd0;
                link_open = 1'b0;
                if (cmd == CMD_WRITE) begin
                    emit(1'b0, {dst_mac[15:0], src_mac}, MASK_ALL, 1'b0);
                    emit(1'b0, {CMD_WRITE, req_id, ftype, dst_mac[47:16]}, MASK_ALL, 1'b0);
                    emit(1'b0, {TRAILER, 16'h0000, req_len}, MASK_ALL, 1'b1);
                end
            end else begin
                link_open = 1'b1;
            end
        end else begin
            if (!fwd_active) begin
                read_armed = 1'b0;
                pkt_bytes = 16'd0;
                fwd_active = 1'b1;
                emit(1'b0, {dst_mac[15:0], src_mac}, MASK_ALL, 1'b0);
                emit(1'b0, {CMD_READ, req_id, req_id, ftype[7:0], dst_mac[47:16]},
                     MASK_ALL, 1'b0);
            end
            emit(1'b0, it.data, MASK_ALL, 1'b0);
            if (it.last) begin
                pkt_bytes = pkt_bytes + keep_bytes(it.keep);
                emit(1'b0, {TRAILER, 16'h0000, pkt_bytes}, MASK_ALL, 1'b1);
                fwd_active = 1'b0;
            end else begin
                pkt_bytes = pkt_bytes + 16'd8;
            end
        end
        if (out_words_due.size() > n_before) begin
            r = out_words_due.pop_back();
            r.run_end = 1'b1;
            out_words_due.push_back(r);
        end
    endtask

    function automatic logic [63:0] rand64();
        rand64 = {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand_cmd();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            rand_cmd = CMD_WRITE;
        end else if (pick < 8) begin
            rand_cmd = CMD_READ;
        end else begin
            rand_cmd = 8'($urandom);
        end
    endfunction

    task automatic add_word(input logic op, input logic [63:0] d, input logic [7:0] k,
                            input logic l);
        t_in w;
        w.operation = op;
        w.data      = d;
        w.keep      = k;
        w.last      = l;
        in_words.push_back(w);
    endtask

    task automatic add_header(input logic [7:0] c, input logic [15:0] len, input int n,
                              input logic close);
        logic [63:0] w;
        int          i;
        for (i = 0; i < n; i++) begin
            case (i)
                0:       w = rand64();
                1:       w = {c, 56'(rand64())};
                default: w = {48'(rand64()), len};
            endcase
            add_word(1'b0, w, 8'($urandom), close && (i == n - 1));
        end
    endtask

    task automatic build_stimulus();
        int          kind;
        int          nd;
        int          i;
        logic [15:0] len;
        logic [7:0]  k;

        add_word(1'b1, '1, 8'hFF, 1'b1);
        add_word(1'b0, '1, 8'hFF, 1'b0);
        add_word(1'b0, {CMD_WRITE, 56'hFF_FFFF_FFFF_FFFF}, 8'h00, 1'b0);
        add_word(1'b0, 64'd12, 8'hFF, 1'b0);
        add_word(1'b0, 64'd0, 8'h00, 1'b0);
        add_word(1'b0, '1, 8'hFF, 1'b1);
        add_word(1'b0, 64'd0, 8'h00, 1'b0);
        add_word(1'b0, {CMD_READ, 56'h0}, 8'h00, 1'b0);
        add_word(1'b0, 64'd5, 8'h00, 1'b0);
        add_word(1'b1, 64'h0123_4567_89AB_CDEF, 8'hFF, 1'b1);
        add_word(1'b0, rand64(), 8'hFF, 1'b1);
        add_word(1'b1, 64'd0, 8'h00, 1'b0);
        add_word(1'b0, rand64(), 8'hFF, 1'b0);
        add_word(1'b1, '1, 8'h07, 1'b1);
        add_word(1'b1, '1, 8'hFF, 1'b1);
        add_word(1'b0, '1, 8'hFF, 1'b1);
        add_word(1'b0, 64'hA5A5_5A5A_C3C3_3C3C, 8'h0F, 1'b0);
        add_word(1'b0, {CMD_WRITE, 56'(rand64())}, 8'hF0, 1'b1);
        add_word(1'b0, rand64(), 8'h80, 1'b1);
        add_word(1'b0, rand64(), 8'hFF, 1'b0);
        add_word(1'b0, {CMD_WRITE, 56'(rand64())}, 8'hFF, 1'b0);
        add_word(1'b0, 64'd100, 8'hFF, 1'b0);
        add_word(1'b0, rand64(), 8'hA5, 1'b1);
        n_directed = in_words.size();

        while (in_words.size() < n_directed + RANDOM_WORDS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                if ($urandom_range(0, 7) == 0) begin
                    len = 16'($urandom);
                    nd = $urandom_range(0, 4);
                end else begin
                    len = 16'($urandom_range(0, 48));
                    nd = (len + 7) / 8 + (($urandom_range(0, 3) == 0) ? 1 : 0);
                end
                add_header(CMD_WRITE, len, 3, nd == 0);
                for (i = 0; i < nd; i++) begin
                    add_word(1'b0, rand64(), 8'($urandom), i == nd - 1);
                end
            end else if (kind < 75) begin
                nd = $urandom_range(0, 1);
                add_header(CMD_READ, 16'($urandom), 3, nd == 0);
                for (i = 0; i < nd; i++) begin
                    add_word(1'b0, rand64(), 8'($urandom), 1'b1);
                end
                nd = $urandom_range(1, 4);
                for (i = 0; i < nd; i++) begin
                    if (i > 0 && $urandom_range(0, 9) == 0) begin
                        add_word(1'b0, rand64(), 8'($urandom), 1'($urandom));
                    end
                    if (i == nd - 1 && $urandom_range(0, 3) != 0) begin
                        k = 8'((16'd1 << $urandom_range(1, 8)) - 16'd1);
                    end else begin
                        k = 8'($urandom);
                    end
                    add_word(1'b1, rand64(), k, i == nd - 1);
                end
            end else if (kind < 88) begin
                add_header(rand_cmd(), 16'($urandom), $urandom_range(1, 3), 1'b1);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    add_word(1'($urandom), rand64(), 8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            progress = 1'b0;
            if (i_pop && !o_empty) begin
                progress = 1'b1;
                words_popped++;
                if (out_words_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, got acc=%b port=%b word=%h mask=%h",
                             $time, o_result.accepted, o_result.port, o_result.word,
                             o_result.byte_mask);
                end else begin
                    due = out_words_due.pop_front();
                    if (o_result !== due) begin
                        mismatches++;
                        $display("%0t: mismatch, expected acc=%b port=%b word=%h mask=%h fend=%b rend=%b",
                                 $time, due.accepted, due.port, due.word, due.byte_mask,
                                 due.frame_end, due.run_end);
                        $display("%0t:           got acc=%b port=%b word=%h mask=%h fend=%b rend=%b",
                                 $time, o_result.accepted, o_result.port, o_result.word,
                                 o_result.byte_mask, o_result.frame_end, o_result.run_end);
                    end
                end
            end
            if (i_push && !o_full) begin
                progress = 1'b1;
                bridge_outputs(i_item);
                words_pushed++;
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (words_pushed != seen_pushed) begin
                seen_pushed = words_pushed;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                i_push <= 1'b0;
            end else if (words_pushed < in_words.size()) begin
                i_push <= 1'b1;
                i_item <= in_words[words_pushed];
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Once per run the output side stops long enough for the job queue to fill.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_pop <= 1'b0;
        end else if (!held_once && words_pushed >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            i_pop <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                pop_mode = t_pop_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(5, 40);
            end else begin
                mode_left--;
            end
            case (pop_mode)
                POP_ALWAYS: i_pop <= 1'b1;
                POP_HALF:   i_pop <= 1'($urandom);
                POP_SPARSE: i_pop <= ($urandom_range(0, 3) == 0);
                default:    i_pop <= 1'(mode_left);
            endcase
        end
    end

    initial begin
        hdr_cnt    = 2'd0;
        fwd_active = 1'b0;
        link_open  = 1'b0;
        dst_mac    = '0;
        src_mac    = '0;
        ftype      = '0;
        req_id     = '0;
        cmd        = '0;
        req_len    = '0;
        wr_left    = '0;
        pkt_bytes  = '0;
        read_armed = 1'b0;
        build_stimulus();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (words_pushed < in_words.size() || out_words_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d input words (%0d directed), %0d of them refused.",
                 words_pushed, n_directed, refusals);
        $display("Checked %0d result words: %0d to tx, %0d on the link.",
                 words_popped, tx_words, link_out);
        if (mismatches == 0 && out_words_due.size() == 0) begin
            $display("[ethernet_command_bridge] OK");
        end else begin
            $display("[ethernet_command_bridge] ERROR");
        end
        $finish;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("[ethernet_command_bridge] ERROR");
        $finish;
    end

endmodule
